@@ sv/mbrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, codes and the CRC-16 byte update for the Modbus RTU response
// deframer.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 9;
  localparam int unsigned CRC_W   = 16;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;

  localparam logic [BYTE_W-1:0] FC_READ_HOLDING = 8'd3;
  localparam logic [BYTE_W-1:0] FC_READ_INPUT   = 8'd4;
  localparam logic [BYTE_W-1:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [BYTE_W-1:0] FC_WRITE_MULTI  = 8'd16;

  localparam logic [INDEX_W-1:0] FIXED_FRAME_LEN = 9'd8;
  localparam logic [INDEX_W-1:0] READ_OVERHEAD   = 9'd5;
  localparam logic [INDEX_W:0]   CRC_BYTES       = 10'd2;

  localparam logic [INDEX_W-1:0] POS_ADDRESS  = 9'd0;
  localparam logic [INDEX_W-1:0] POS_FUNCTION = 9'd1;
  localparam logic [INDEX_W-1:0] POS_COUNT    = 9'd2;

  typedef enum logic [2:0] {
    STATUS_BUSY     = 3'd0,
    STATUS_GOOD     = 3'd1,
    STATUS_BAD_ADDR = 3'd2,
    STATUS_BAD_FUNC = 3'd3,
    STATUS_BAD_CRC  = 3'd4,
    STATUS_HALTED   = 3'd5
  } mbrtu_status_t;

  typedef struct packed {
    logic [INDEX_W-1:0] position;
    logic [INDEX_W-1:0] frame_length;
    logic [BYTE_W-1:0]  function_code;
    logic [CRC_W-1:0]   running_crc;
    logic [BYTE_W-1:0]  crc_low;
    logic               halted;
  } mbrtu_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               frame_end;
    mbrtu_status_t      frame_status;
  } mbrtu_result_t;

  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ sv/mbrtu_frame_core.sv @@
// ----------------------------------------------------------------------------
// mbrtu_frame_core
// Per-byte frame decision: from the held state and one received byte, gives
// the echoed result and the state for the next byte.
// ----------------------------------------------------------------------------
module mbrtu_frame_core (
  input  mbrtu_pkg::mbrtu_state_t  state_cur,
  input  logic [7:0]               rx_byte,
  input  logic [7:0]               expected_address,
  output mbrtu_pkg::mbrtu_state_t  state_nxt,
  output mbrtu_pkg::mbrtu_result_t result
);

  logic                              is_read_fc;
  logic [mbrtu_pkg::INDEX_W-1:0]     len_eff;
  logic [mbrtu_pkg::INDEX_W:0]       idx_plus;
  logic [mbrtu_pkg::INDEX_W:0]       len_ext;
  logic [mbrtu_pkg::CRC_W-1:0]       crc_upd;
  logic [mbrtu_pkg::CRC_W-1:0]       received;

  always_comb begin
    is_read_fc = (state_cur.function_code == mbrtu_pkg::FC_READ_HOLDING) ||
                 (state_cur.function_code == mbrtu_pkg::FC_READ_INPUT);
    if ((state_cur.position == mbrtu_pkg::POS_COUNT) && is_read_fc) begin
      len_eff = {1'b0, rx_byte} + mbrtu_pkg::READ_OVERHEAD;
    end else begin
      len_eff = state_cur.frame_length;
    end
    idx_plus = {1'b0, state_cur.position} + mbrtu_pkg::CRC_BYTES;
    len_ext  = {1'b0, len_eff};
    crc_upd  = mbrtu_pkg::crc16_byte(state_cur.running_crc, rx_byte);
    received = {rx_byte, state_cur.crc_low};

    state_nxt           = state_cur;
    result.data_byte    = rx_byte;
    result.byte_index   = state_cur.position;
    result.frame_end    = 1'b0;
    result.frame_status = mbrtu_pkg::STATUS_BUSY;

    if (state_cur.halted) begin
      result.byte_index   = '0;
      result.frame_status = mbrtu_pkg::STATUS_HALTED;
    end else if (state_cur.position == mbrtu_pkg::POS_ADDRESS) begin
      if (rx_byte != expected_address) begin
        result.frame_status = mbrtu_pkg::STATUS_BAD_ADDR;
        result.frame_end    = 1'b1;
        state_nxt.halted    = 1'b1;
      end else begin
        state_nxt.running_crc = mbrtu_pkg::crc16_byte(mbrtu_pkg::CRC_INIT, rx_byte);
        state_nxt.position    = mbrtu_pkg::POS_FUNCTION;
      end
    end else if (state_cur.position == mbrtu_pkg::POS_FUNCTION) begin
      state_nxt.function_code = rx_byte;
      if ((rx_byte == mbrtu_pkg::FC_READ_HOLDING) ||
          (rx_byte == mbrtu_pkg::FC_READ_INPUT)) begin
        state_nxt.running_crc = crc_upd;
        state_nxt.position    = mbrtu_pkg::POS_COUNT;
      end else if ((rx_byte == mbrtu_pkg::FC_WRITE_SINGLE) ||
                   (rx_byte == mbrtu_pkg::FC_WRITE_MULTI)) begin
        state_nxt.frame_length = mbrtu_pkg::FIXED_FRAME_LEN;
        state_nxt.running_crc  = crc_upd;
        state_nxt.position     = mbrtu_pkg::POS_COUNT;
      end else begin
        result.frame_status = mbrtu_pkg::STATUS_BAD_FUNC;
        result.frame_end    = 1'b1;
        state_nxt.halted    = 1'b1;
      end
    end else begin
      state_nxt.frame_length = len_eff;
      if (idx_plus < len_ext) begin
        state_nxt.running_crc = crc_upd;
        state_nxt.position    = state_cur.position + 9'd1;
      end else if (idx_plus == len_ext) begin
        state_nxt.crc_low  = rx_byte;
        state_nxt.position = state_cur.position + 9'd1;
      end else begin
        result.frame_end = 1'b1;
        if (received == state_cur.running_crc) begin
          result.frame_status   = mbrtu_pkg::STATUS_GOOD;
          state_nxt.position    = '0;
          state_nxt.running_crc = mbrtu_pkg::CRC_INIT;
        end else begin
          result.frame_status = mbrtu_pkg::STATUS_BAD_CRC;
          state_nxt.halted    = 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/modbus_rtu_response_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer_unit
// Splits a received byte stream into Modbus RTU response frames, checks the
// address, function code and CRC-16, and echoes every byte with its status.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                    Content
//  in       slave      in_tvalid/tready/tdata   rx_byte
//  out      master     out_tvalid/tready/tdata  data_byte, byte_index
//                      out_tlast, out_tuser     frame_end, frame_status
//  cfg      write      cfg_wr_en/cfg_wr_data    expected_address
//
// Each request is held in an input register and decided combinationally into
// the result register, so one request per cycle is sustained while the output
// is not stalled. A stalled result holds the pipeline; the input register
// takes a request while the result waits only if it is empty. Synchronous
// active-low reset clears the frame state; after any framing error the unit
// echoes bytes with the halted status until reset.
// ----------------------------------------------------------------------------
module modbus_rtu_response_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [7:0] data_byte, [16:8] byte_index, rest zero
  output logic        out_tlast,    // frame_end
  output logic [2:0]  out_tuser,    // frame_status
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic                     in_valid_r;
  logic [7:0]               in_byte_r;
  logic                     out_valid_r;
  mbrtu_pkg::mbrtu_result_t out_res_r;
  mbrtu_pkg::mbrtu_state_t  state_r;
  mbrtu_pkg::mbrtu_state_t  state_nxt;
  mbrtu_pkg::mbrtu_result_t res_nxt;
  logic [7:0]               addr_r;
  logic                     advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  mbrtu_frame_core u_core (
    .state_cur        (state_r),
    .rx_byte          (in_byte_r),
    .expected_address (addr_r),
    .state_nxt        (state_nxt),
    .result           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r                <= '0;
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.position      <= '0;
      state_r.frame_length  <= '0;
      state_r.function_code <= '0;
      state_r.running_crc   <= mbrtu_pkg::CRC_INIT;
      state_r.crc_low       <= '0;
      state_r.halted        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        addr_r <= cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.byte_index, out_res_r.data_byte};
  assign out_tlast  = out_res_r.frame_end;
  assign out_tuser  = out_res_r.frame_status;

endmodule
